>>> src/aba_pkg.sv
// ============================================================================
// aba_pkg: shared types and constants of the arena bump allocator
// Holds the request, scan-token and commit records that pass between the
// top level and the slot cells, plus the request kinds and status codes.
// ============================================================================
`default_nettype none

package aba_pkg;

    // Fixed widths of the request and result fields.
    localparam int ADDR_W  = 19;
    localparam int SIZE_W  = 17;
    localparam int ALIGN_W = 4;
    localparam int REFS_W  = 16;
    localparam int PAD_W   = 15;

    // Slot indexes are carried at the width of the largest supported slot count.
    localparam int SLOT_IDX_W = 6;

    localparam logic [SIZE_W-1:0] DEFAULT_CAP_RESET = 17'd4096;
    localparam logic [REFS_W-1:0] REFS_MAX          = 16'hFFFF;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef logic [SLOT_IDX_W-1:0] t_slot_idx;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NO_SLOT   = 2'd1,
        ST_TOO_LARGE = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // Request as held by the top level for the whole scan.
    typedef struct packed {
        logic              kind;
        logic [SIZE_W-1:0] num_bytes;
        logic [ALIGN_W-1:0] align_log2;
        logic              hint_valid;
        logic [ADDR_W-1:0] address;
        logic [SIZE_W-1:0] cap_new;
    } t_req;

    // Token that walks down the row of cells, one cell per cycle.
    typedef struct packed {
        logic              valid;
        logic              hit_found;
        t_slot_idx         hit_idx;
        logic              hit_fit;
        logic [ADDR_W-1:0] hit_addr;
        logic              ff_found;
        t_slot_idx         ff_idx;
        logic [ADDR_W-1:0] ff_addr;
        logic              new_found;
        t_slot_idx         new_idx;
        logic [ADDR_W-1:0] new_addr;
        logic              new_pad_bad;
    } t_scan;

    // Update broadcast to all cells once the scan has decided.
    typedef struct packed {
        logic      valid;
        t_slot_idx idx;
        logic      open_new;
    } t_commit;

endpackage

`default_nettype wire

>>> src/aba_cell.sv
// ============================================================================
// aba_cell: one arena slot of the allocator
// Keeps the slot's fill top, capacity and reference count, adds its findings
// to the passing scan token, and applies the committed update for its slot.
// ============================================================================
`default_nettype none

module aba_cell #(
    parameter int IDX         = 0,
    parameter int REGION_LOG2 = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire aba_pkg::t_req    i_req,
    input  wire aba_pkg::t_scan   i_scan,
    output aba_pkg::t_scan        o_scan,
    input  wire aba_pkg::t_commit i_commit
);
    import aba_pkg::*;

    localparam logic [63:0] BASE_FULL = 64'(IDX) << REGION_LOG2;
    localparam logic [ADDR_W-1:0] BASE_ADDR = BASE_FULL[ADDR_W-1:0];
    localparam logic [PAD_W-1:0]  BASE_LOW  = BASE_FULL[PAD_W-1:0];
    localparam logic [ADDR_W-1:0] OFS_MASK  =
        ADDR_W'((64'(1) << REGION_LOG2) - 64'd1);

    logic              r_open;
    logic [SIZE_W-1:0] r_top;
    logic [SIZE_W-1:0] r_cap;
    logic [REFS_W-1:0] r_refs;
    t_scan             r_scan;
    t_scan             n_scan;

    logic [PAD_W-1:0]  align_mask;
    logic [PAD_W-1:0]  abs_low;
    logic [PAD_W-1:0]  pad;
    logic [ADDR_W-1:0] addr_hi;
    logic [ADDR_W-1:0] addr_lo;
    logic              fits;
    logic              holds;
    logic [ADDR_W-1:0] cand_addr;
    logic              sel;
    logic [REFS_W-1:0] refs_dec;

    // Padding up to the alignment, taken from the low bits of base plus top.
    assign align_mask = PAD_W'((16'(1) << i_req.align_log2) - 16'd1);
    assign abs_low    = BASE_LOW + r_top[PAD_W-1:0];
    assign pad        = (~abs_low + PAD_W'(1)) & align_mask;

    assign addr_hi = i_req.address >> REGION_LOG2;
    assign addr_lo = i_req.address & OFS_MASK;

    assign fits  = r_open && ((ADDR_W'(r_top) + ADDR_W'(pad) + ADDR_W'(i_req.num_bytes))
                              < ADDR_W'(r_cap));
    assign holds = r_open && (addr_hi == ADDR_W'(IDX)) && (addr_lo < ADDR_W'(r_top));
    assign cand_addr = BASE_ADDR + ADDR_W'(r_top) + ADDR_W'(pad);

    always_comb begin
        n_scan = i_scan;
        if (!i_scan.hit_found && holds) begin
            n_scan.hit_found = 1'b1;
            n_scan.hit_idx   = t_slot_idx'(IDX);
            n_scan.hit_fit   = fits;
            n_scan.hit_addr  = cand_addr;
        end
        if (!i_scan.ff_found && fits) begin
            n_scan.ff_found = 1'b1;
            n_scan.ff_idx   = t_slot_idx'(IDX);
            n_scan.ff_addr  = cand_addr;
        end
        // A slot that is not open yet has a top of zero.
        if (!i_scan.new_found && !r_open) begin
            n_scan.new_found   = 1'b1;
            n_scan.new_idx     = t_slot_idx'(IDX);
            n_scan.new_addr    = cand_addr;
            n_scan.new_pad_bad = (18'(pad) + 18'(i_req.num_bytes)) > 18'(i_req.cap_new);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan.valid <= 1'b0;
        end else begin
            r_scan.valid <= i_scan.valid;
        end
        r_scan.hit_found   <= n_scan.hit_found;
        r_scan.hit_idx     <= n_scan.hit_idx;
        r_scan.hit_fit     <= n_scan.hit_fit;
        r_scan.hit_addr    <= n_scan.hit_addr;
        r_scan.ff_found    <= n_scan.ff_found;
        r_scan.ff_idx      <= n_scan.ff_idx;
        r_scan.ff_addr     <= n_scan.ff_addr;
        r_scan.new_found   <= n_scan.new_found;
        r_scan.new_idx     <= n_scan.new_idx;
        r_scan.new_addr    <= n_scan.new_addr;
        r_scan.new_pad_bad <= n_scan.new_pad_bad;
    end

    assign o_scan = r_scan;

    assign sel      = i_commit.valid && (i_commit.idx == t_slot_idx'(IDX));
    assign refs_dec = (r_refs == '0) ? '0 : r_refs - REFS_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_top  <= '0;
            r_cap  <= '0;
            r_refs <= '0;
        end else if (sel) begin
            if (i_req.kind == KIND_ALLOC) begin
                if (i_commit.open_new) begin
                    r_open <= 1'b1;
                    r_cap  <= i_req.cap_new;
                end
                r_top <= r_top + SIZE_W'(pad) + i_req.num_bytes;
                if (r_refs != REFS_MAX) begin
                    r_refs <= r_refs + REFS_W'(1);
                end
            end else begin
                r_refs <= refs_dec;
                if (refs_dec == '0) begin
                    r_top <= '0;
                end else if ((20'(addr_lo) + 20'(i_req.num_bytes)) == 20'(r_top)) begin
                    r_top <= r_top - i_req.num_bytes;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> src/arena_bump_allocator.sv
// ============================================================================
// arena_bump_allocator: reference-counted bump allocator over arena slots
// A request enters on the input channel and leaves one result on the output
// channel. Requests either allocate (kind 0) or free (kind 1) a block.
// Usage: drive i_in_valid with the request fields; the request is taken at an
// edge where o_in_stall is low. One request is worked on at a time: it is
// registered, then a launch flag sends the scan token through the slot
// cells, one cell per cycle, and the decision is loaded into the output
// register; a new request can be taken in the cycle after that load.
// The result waits in an output register while i_out_stall is high; the next
// request is accepted meanwhile, and its commit waits until the register frees.
// Reset (synchronous, active low) closes all slots, clears all counts and
// sets the default capacity register to 4096. i_cfg_we writes it; the user
// must do so only while idle, as the block itself does not enforce this.
// ============================================================================
`default_nettype none

module arena_bump_allocator #(
    parameter int NUM_SLOTS    = 8,
    parameter int REGION_BYTES = 65536
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration register: default capacity of a newly opened slot.
    input  wire logic        i_cfg_we,
    input  wire logic [16:0] i_cfg_data,
    // Request channel.
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_kind,
    input  wire logic [16:0] i_num_bytes,
    input  wire logic [3:0]  i_align_log2,
    input  wire logic        i_hint_valid,
    input  wire logic [18:0] i_address,
    // Result channel.
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [18:0]      o_result_address,
    output logic [1:0]       o_status
);
    import aba_pkg::*;

    // Regions are a power of two in size, so a slot's base is its index
    // shifted left by this amount.
    localparam int REGION_LOG2 = $clog2(REGION_BYTES);

    t_state              r_state;
    t_state              n_state;
    logic [SIZE_W-1:0]   r_def_cap;
    t_req                r_req;
    logic                r_launch;
    t_scan               r_end;
    logic                r_out_valid;
    logic [ADDR_W-1:0]   r_out_addr;
    t_status             r_out_status;

    t_scan               chain [NUM_SLOTS+1];
    t_scan               end_tok;
    t_commit             commit;
    logic                accept;
    logic                out_free;
    logic                end_ready;
    logic                finish;
    logic                cap_too_big;
    t_status             dec_status;
    logic [ADDR_W-1:0]   dec_addr;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_cap <= DEFAULT_CAP_RESET;
        end else if (i_cfg_we) begin
            r_def_cap <= i_cfg_data;
        end
    end

    // The capacity a new slot would get is worked out once, on acceptance.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.kind       <= i_kind;
            r_req.num_bytes  <= i_num_bytes;
            r_req.align_log2 <= i_align_log2;
            r_req.hint_valid <= i_hint_valid;
            r_req.address    <= i_address;
            r_req.cap_new    <= (r_def_cap > i_num_bytes) ? r_def_cap : i_num_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_launch <= 1'b0;
        end else begin
            r_launch <= accept;
        end
    end

    // A fresh token enters the first cell with nothing found yet.
    always_comb begin
        chain[0]       = '0;
        chain[0].valid = r_launch;
    end

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        aba_cell #(
            .IDX         (g),
            .REGION_LOG2 (REGION_LOG2)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_req    (r_req),
            .i_scan   (chain[g]),
            .o_scan   (chain[g+1]),
            .i_commit (commit)
        );
    end

    // The token leaving the last cell is always kept, so that when the output
    // register is still occupied the decision can be made in a later cycle.
    always_ff @(posedge i_clk) begin
        if (chain[NUM_SLOTS].valid) begin
            r_end <= chain[NUM_SLOTS];
        end
    end

    assign end_tok   = (r_state == S_DONE) ? r_end : chain[NUM_SLOTS];
    assign end_ready = ((r_state == S_SCAN) && chain[NUM_SLOTS].valid) ||
                       (r_state == S_DONE);
    assign finish    = end_ready && out_free;

    assign cap_too_big = 32'(r_req.cap_new) > 32'(REGION_BYTES);

    // Decision: hint slot first, then the first slot that fits, and otherwise
    // a new slot. A free needs the slot that holds the address.
    always_comb begin
        dec_status      = ST_DONE;
        dec_addr        = '0;
        commit.idx      = '0;
        commit.open_new = 1'b0;
        if (r_req.kind == KIND_FREE) begin
            if (end_tok.hit_found) begin
                commit.idx = end_tok.hit_idx;
            end else begin
                dec_status = ST_NOT_FOUND;
            end
        end else if (r_req.hint_valid && end_tok.hit_found && end_tok.hit_fit) begin
            commit.idx = end_tok.hit_idx;
            dec_addr   = end_tok.hit_addr;
        end else if (end_tok.ff_found) begin
            commit.idx = end_tok.ff_idx;
            dec_addr   = end_tok.ff_addr;
        end else if (cap_too_big || (end_tok.new_found && end_tok.new_pad_bad)) begin
            dec_status = ST_TOO_LARGE;
        end else if (!end_tok.new_found) begin
            dec_status = ST_NO_SLOT;
        end else begin
            commit.idx      = end_tok.new_idx;
            commit.open_new = 1'b1;
            dec_addr        = end_tok.new_addr;
        end
        commit.valid = finish && (dec_status == ST_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (chain[NUM_SLOTS].valid) begin
                    n_state = out_free ? S_IDLE : S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_addr   <= dec_addr;
            r_out_status <= dec_status;
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_result_address = r_out_addr;
    assign o_status         = r_out_status;

endmodule

`default_nettype wire
